[rtl/csu_pkg.sv]
// types and constants for the c string literal unescape block
// shared by csu_step and c_string_literal_unescape_core; no dependencies
package csu_pkg;

	localparam int CHAR_BITS = 8;
	localparam int CH_W      = 8;
	localparam int VAL_W     = 8;
	localparam int KIND_W    = 3;
	localparam int DIG_W     = 4;

	// result queue between the decode step and the master side
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// source characters
	localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CH_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;
	localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CH_W-1:0] CH_SEVEN  = 8'h37;
	localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
	localparam logic [CH_W-1:0] CH_QMARK  = 8'h3F;
	localparam logic [CH_W-1:0] CH_UP_A   = 8'h41;
	localparam logic [CH_W-1:0] CH_UP_F   = 8'h46;
	localparam logic [CH_W-1:0] CH_UP_U   = 8'h55;
	localparam logic [CH_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CH_W-1:0] CH_LO_A   = 8'h61;
	localparam logic [CH_W-1:0] CH_LO_B   = 8'h62;
	localparam logic [CH_W-1:0] CH_LO_F   = 8'h66;
	localparam logic [CH_W-1:0] CH_LO_N   = 8'h6E;
	localparam logic [CH_W-1:0] CH_LO_R   = 8'h72;
	localparam logic [CH_W-1:0] CH_LO_T   = 8'h74;
	localparam logic [CH_W-1:0] CH_LO_U   = 8'h75;
	localparam logic [CH_W-1:0] CH_LO_V   = 8'h76;
	localparam logic [CH_W-1:0] CH_LO_X   = 8'h78;

	// decoded control characters
	localparam logic [CH_W-1:0] C_BEL = 8'h07;
	localparam logic [CH_W-1:0] C_BS  = 8'h08;
	localparam logic [CH_W-1:0] C_HT  = 8'h09;
	localparam logic [CH_W-1:0] C_LF  = 8'h0A;
	localparam logic [CH_W-1:0] C_VT  = 8'h0B;
	localparam logic [CH_W-1:0] C_FF  = 8'h0C;
	localparam logic [CH_W-1:0] C_CR  = 8'h0D;

	localparam logic [DIG_W-1:0] OCT_REST = 4'd2;
	localparam logic [DIG_W-1:0] HEX_U_N  = 4'd4;
	localparam logic [DIG_W-1:0] HEX_UU_N = 4'd8;

	typedef enum logic [5:0] {
		M_IDLE = 6'b000001,
		M_BODY = 6'b000010,
		M_ESC  = 6'b000100,
		M_OCT  = 6'b001000,
		M_HEXN = 6'b010000,
		M_HEXX = 6'b100000
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_CHAR     = 3'd0,
		K_DONE     = 3'd1,
		K_NOQUOTE  = 3'd2,
		K_EOF      = 3'd3,
		K_UNKNOWN  = 3'd4,
		K_BADDIGIT = 3'd5
	} kind_t;

	typedef struct packed {
		mode_t                mode;
		logic [DIG_W-1:0]     digits;
		logic [CHAR_BITS-1:0] acc;
	} state_t;

	typedef struct packed {
		kind_t            kind;
		logic [VAL_W-1:0] value;
		logic             last;
	} result_t;

	// up to two results from one character, first one in res0
	typedef struct packed {
		logic [1:0] n;
		result_t    res0;
		result_t    res1;
	} step_t;

endpackage

[rtl/csu_step.sv]
// decode step: next state and results for one source character
// uses csu_pkg
module csu_step (
	input  csu_pkg::state_t            st,
	input  logic [csu_pkg::CH_W-1:0]   ch,
	output csu_pkg::state_t            st_nxt,
	output csu_pkg::step_t             step
);

	function automatic csu_pkg::result_t mk_res(csu_pkg::kind_t k,
		logic [csu_pkg::VAL_W-1:0] v);
		csu_pkg::result_t r;
		r.kind  = k;
		r.value = (k == csu_pkg::K_CHAR) ? v : '0;
		r.last  = 1'b0;
		return r;
	endfunction

	// bit 4 set when the character is not a hex digit
	function automatic logic [4:0] hex_val(logic [csu_pkg::CH_W-1:0] c);
		logic [4:0] h;
		h = 5'h10;
		if (c >= csu_pkg::CH_ZERO && c <= csu_pkg::CH_NINE)
			h = {1'b0, c[3:0]};
		else if ((c >= csu_pkg::CH_LO_A && c <= csu_pkg::CH_LO_F) ||
			(c >= csu_pkg::CH_UP_A && c <= csu_pkg::CH_UP_F))
			h = {1'b0, 4'(c[3:0] + 4'd9)};
		return h;
	endfunction

	csu_pkg::state_t  idle_st;
	csu_pkg::state_t  body_st;
	csu_pkg::result_t body_res;
	logic             body_emit;
	logic [4:0]       hv;
	logic             is_oct;
	logic [csu_pkg::CHAR_BITS-1:0] acc_o;
	logic [csu_pkg::CHAR_BITS-1:0] acc_h;
	logic [csu_pkg::DIG_W-1:0]     dig_dec;
	logic [csu_pkg::CH_W-1:0]      simple_v;
	logic                          simple_ok;
	logic [1:0]                    n;
	csu_pkg::result_t              r0;
	csu_pkg::result_t              r1;

	assign hv      = hex_val(ch);
	assign is_oct  = (ch >= csu_pkg::CH_ZERO) && (ch <= csu_pkg::CH_SEVEN);
	assign acc_o   = {st.acc[csu_pkg::CHAR_BITS-4:0], ch[2:0]};
	assign acc_h   = {st.acc[csu_pkg::CHAR_BITS-5:0], hv[3:0]};
	assign dig_dec = st.digits - 1'b1;

	always_comb begin
		idle_st.mode   = csu_pkg::M_IDLE;
		idle_st.digits = '0;
		idle_st.acc    = '0;
	end

	// ordinary literal character; also used right after a \x run ends
	always_comb begin
		body_st.mode   = csu_pkg::M_BODY;
		body_st.digits = st.digits;
		body_st.acc    = '0;
		body_emit      = 1'b1;
		body_res       = mk_res(csu_pkg::K_CHAR, ch);
		if (ch == csu_pkg::CH_NUL) begin
			body_st  = idle_st;
			body_res = mk_res(csu_pkg::K_EOF, '0);
		end else if (ch == csu_pkg::CH_BSLASH) begin
			body_st.mode = csu_pkg::M_ESC;
			body_emit    = 1'b0;
		end else if (ch == csu_pkg::CH_QUOTE) begin
			body_st  = idle_st;
			body_res = mk_res(csu_pkg::K_DONE, '0);
		end
	end

	always_comb begin
		simple_ok = 1'b1;
		simple_v  = ch;
		unique case (ch)
			csu_pkg::CH_BSLASH, csu_pkg::CH_SLASH,
			csu_pkg::CH_QUOTE, csu_pkg::CH_QMARK: simple_v = ch;
			csu_pkg::CH_LO_A: simple_v = csu_pkg::C_BEL;
			csu_pkg::CH_LO_B: simple_v = csu_pkg::C_BS;
			csu_pkg::CH_LO_F: simple_v = csu_pkg::C_FF;
			csu_pkg::CH_LO_N: simple_v = csu_pkg::C_LF;
			csu_pkg::CH_LO_R: simple_v = csu_pkg::C_CR;
			csu_pkg::CH_LO_T: simple_v = csu_pkg::C_HT;
			csu_pkg::CH_LO_V: simple_v = csu_pkg::C_VT;
			default: simple_ok = 1'b0;
		endcase
	end

	always_comb begin
		st_nxt = st;
		n      = 2'd0;
		r0     = mk_res(csu_pkg::K_CHAR, '0);
		r1     = mk_res(csu_pkg::K_CHAR, '0);
		unique case (st.mode)
			csu_pkg::M_IDLE: begin
				if (ch == csu_pkg::CH_QUOTE) begin
					st_nxt.mode = csu_pkg::M_BODY;
				end else begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_NOQUOTE, '0);
				end
			end
			csu_pkg::M_BODY: begin
				st_nxt = body_st;
				n      = {1'b0, body_emit};
				r0     = body_res;
			end
			csu_pkg::M_ESC: begin
				if (ch == csu_pkg::CH_NUL) begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_EOF, '0);
				end else if (ch >= csu_pkg::CH_ZERO && ch <= csu_pkg::CH_NINE) begin
					if (!is_oct) begin
						st_nxt = idle_st;
						n      = 2'd1;
						r0     = mk_res(csu_pkg::K_BADDIGIT, '0);
					end else begin
						st_nxt.mode   = csu_pkg::M_OCT;
						st_nxt.digits = csu_pkg::OCT_REST;
						st_nxt.acc    = {{(csu_pkg::CHAR_BITS-3){1'b0}}, ch[2:0]};
					end
				end else if (ch == csu_pkg::CH_LO_U || ch == csu_pkg::CH_UP_U) begin
					st_nxt.mode   = csu_pkg::M_HEXN;
					st_nxt.digits = (ch == csu_pkg::CH_LO_U) ? csu_pkg::HEX_U_N
						: csu_pkg::HEX_UU_N;
					st_nxt.acc    = '0;
				end else if (ch == csu_pkg::CH_LO_X) begin
					st_nxt.mode = csu_pkg::M_HEXX;
					st_nxt.acc  = '0;
				end else if (simple_ok) begin
					st_nxt.mode = csu_pkg::M_BODY;
					n           = 2'd1;
					r0          = mk_res(csu_pkg::K_CHAR, simple_v);
				end else begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_UNKNOWN, '0);
				end
			end
			csu_pkg::M_OCT: begin
				if (ch == csu_pkg::CH_NUL) begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_EOF, '0);
				end else if (!is_oct) begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_BADDIGIT, '0);
				end else if (dig_dec == '0) begin
					st_nxt.mode   = csu_pkg::M_BODY;
					st_nxt.digits = dig_dec;
					st_nxt.acc    = '0;
					n             = 2'd1;
					r0            = mk_res(csu_pkg::K_CHAR, acc_o[csu_pkg::VAL_W-1:0]);
				end else begin
					st_nxt.digits = dig_dec;
					st_nxt.acc    = acc_o;
				end
			end
			csu_pkg::M_HEXN: begin
				if (ch == csu_pkg::CH_NUL) begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_EOF, '0);
				end else if (hv[4]) begin
					st_nxt = idle_st;
					n      = 2'd1;
					r0     = mk_res(csu_pkg::K_BADDIGIT, '0);
				end else if (dig_dec == '0) begin
					st_nxt.mode   = csu_pkg::M_BODY;
					st_nxt.digits = dig_dec;
					st_nxt.acc    = '0;
					n             = 2'd1;
					r0            = mk_res(csu_pkg::K_CHAR, acc_h[csu_pkg::VAL_W-1:0]);
				end else begin
					st_nxt.digits = dig_dec;
					st_nxt.acc    = acc_h;
				end
			end
			csu_pkg::M_HEXX: begin
				if (!hv[4]) begin
					st_nxt.acc = acc_h;
				end else begin
					// run ends: emit value, then the character goes through the body path
					st_nxt = body_st;
					r0     = mk_res(csu_pkg::K_CHAR, st.acc[csu_pkg::VAL_W-1:0]);
					r1     = body_res;
					n      = body_emit ? 2'd2 : 2'd1;
				end
			end
			default: st_nxt = idle_st;
		endcase
		r0.last = (n == 2'd1);
		r1.last = (n == 2'd2);
	end

	assign step.n    = n;
	assign step.res0 = r0;
	assign step.res1 = r1;

endmodule

[rtl/c_string_literal_unescape_core.sv]
// C string literal decoder: one source character per input word
// top level; uses csu_pkg and csu_step
//
// slave side: s_tvalid/s_tready/s_tdata carry one source character per word,
// a zero character marks end of input. master side carries the results:
// m_tuser gives the kind (decoded character, string done or an error code),
// m_tdata the decoded character (zero for anything but a character) and
// m_tlast marks the last result caused by one source character.
// a character makes zero, one or two results; an error returns the decoder
// to idle, waiting for the next opening quote.
// a taken character waits in the input register; the decode step writes its
// results to the result queue, which feeds the master side. one character
// is taken every cycle as long as the results drain; the rate is set by the
// single master port, one result per cycle, behind the four-word queue.
// when the receiver stalls the queue fills and s_tready drops once fewer
// than two queue slots are free and the input register is occupied.
// reset clears the decoder state, the input register and the result queue.
module c_string_literal_unescape_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] ch
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // [7:0] value
	output logic [csu_pkg::KIND_W-1:0]    m_tuser,   // [2:0] kind
	output logic                          m_tlast
);

	logic                          valid_s1;
	logic [csu_pkg::CH_W-1:0]      ch_s1;
	csu_pkg::state_t               state_q;
	csu_pkg::state_t               state_nxt;
	csu_pkg::step_t                step;

	csu_pkg::result_t              oq_q [csu_pkg::OQ_DEPTH];
	logic [csu_pkg::OQ_AW-1:0]     wr_ptr_q;
	logic [csu_pkg::OQ_AW-1:0]     rd_ptr_q;
	logic [csu_pkg::OQ_CW-1:0]     count_q;

	logic fire;
	logic pop;
	logic s_acc;

	csu_step u_step (
		.st     (state_q),
		.ch     (ch_s1),
		.st_nxt (state_nxt),
		.step   (step)
	);

	// room for two results before the step runs
	assign fire     = valid_s1 &&
		(count_q <= csu_pkg::OQ_CW'(csu_pkg::OQ_DEPTH - 2));
	assign s_tready = !valid_s1 || fire;
	assign s_acc    = s_tvalid && s_tready;

	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;
	assign m_tdata  = oq_q[rd_ptr_q].value;
	assign m_tuser  = oq_q[rd_ptr_q].kind;
	assign m_tlast  = oq_q[rd_ptr_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			state_q.mode   <= csu_pkg::M_IDLE;
			state_q.digits <= '0;
			state_q.acc    <= '0;
			wr_ptr_q       <= '0;
			rd_ptr_q       <= '0;
			count_q        <= '0;
		end else begin
			if (s_acc)
				valid_s1 <= 1'b1;
			else if (fire)
				valid_s1 <= 1'b0;
			if (fire) begin
				state_q  <= state_nxt;
				wr_ptr_q <= wr_ptr_q + csu_pkg::OQ_AW'(step.n);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (fire ? csu_pkg::OQ_CW'(step.n) : '0)
				- csu_pkg::OQ_CW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			ch_s1 <= s_tdata;
		if (fire && step.n != 2'd0)
			oq_q[wr_ptr_q] <= step.res0;
		if (fire && step.n == 2'd2)
			oq_q[wr_ptr_q + 1'b1] <= step.res1;
	end

	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= csu_pkg::OQ_CW'(csu_pkg::OQ_DEPTH))
		else $error("result queue overflow");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(ch_s1))
		else $error("input register lost a word");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		fire && step.n == 2'd2 |->
			step.res0.kind == csu_pkg::K_CHAR && !step.res0.last && step.res1.last)
		else $error("bad result pair");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != csu_pkg::OQ_CW'(csu_pkg::OQ_DEPTH) && count_q != '0 |->
			wr_ptr_q != rd_ptr_q)
		else $error("queue pointers out of step");

endmodule
